FILE: src/msis_pkg.sv
// Shared types and constants for the MIPS subset instruction step block.
package msis_pkg;

  // Default data memory size in bytes; must be a power of two.
  localparam int unsigned DataBytes = 65536;

  localparam logic [31:0] HaltWord = 32'hFFFF_FFFF;

  typedef enum logic [5:0] {
    OP_RTYPE = 6'b000000,
    OP_J     = 6'b000010,
    OP_BEQ   = 6'b000100,
    OP_ADDIU = 6'b001001,
    OP_LW    = 6'b100011,
    OP_SW    = 6'b101011
  } opcode_e;

  typedef enum logic [2:0] {
    ALU_ADDU = 3'd1,
    ALU_SUBU = 3'd3,
    ALU_AND  = 3'd4,
    ALU_OR   = 3'd5,
    ALU_NOR  = 3'd7
  } alu_e;

  typedef struct packed {
    logic        action;
    logic [31:0] instruction;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [31:0] mem_word;
  } out_item_t;

  // Request from the execute stage to the data memory.
  typedef struct packed {
    logic        rd_en;   // word load
    logic        st_en;   // word store
    logic        pl_en;   // single byte preload
    logic [31:0] addr;    // byte address, already wrapped
    logic [31:0] wdata;   // store word, or preload byte in [7:0]
  } dmem_req_t;

endpackage

FILE: src/msis_dmem.sv
// Byte-addressed big-endian data memory: four byte lanes, clearing pass after reset.
module msis_dmem #(
  parameter int unsigned DATA_BYTES = msis_pkg::DataBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  msis_pkg::dmem_req_t req_i,
  output logic [31:0]         rdata_o,
  output logic                busy_o
);

  localparam int unsigned AddrW = $clog2(DATA_BYTES);
  localparam int unsigned RowAw = AddrW - 2;
  localparam int unsigned Rows  = DATA_BYTES / 4;

  logic             clr_q, clr_d;
  logic [RowAw-1:0] clr_row_q, clr_row_d;
  logic [1:0]       off;
  logic [1:0]       off_q;
  logic [RowAw-1:0] row0, row1;
  logic [63:0]      st_dbl;
  logic [31:0]      st_rot;
  logic [31:0]      lanes_w;
  logic [63:0]      rd_dbl;

  assign off    = req_i.addr[1:0];
  assign row0   = req_i.addr[AddrW-1:2];
  assign row1   = row0 + 1'b1;
  assign busy_o = clr_q;

  // store word rotated so that lane L gets byte (L - off) mod 4
  assign st_dbl = {req_i.wdata, req_i.wdata} >> {off, 3'b000};
  assign st_rot = st_dbl[31:0];

  always_comb begin
    clr_d     = clr_q;
    clr_row_d = clr_row_q;
    if (clr_q) begin
      clr_row_d = clr_row_q + 1'b1;
      if (clr_row_q == RowAw'(Rows - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_row_q <= clr_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      off_q <= off;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam logic [1:0] Lane = 2'(l);

    logic [7:0]       mem [Rows];
    logic [RowAw-1:0] lane_row;
    logic [RowAw-1:0] wr_row;
    logic [7:0]       wr_byte;
    logic             wr_en;
    logic [7:0]       rd_q;

    // bytes of an unaligned word that fall below the offset live in the next row
    assign lane_row = (Lane < off) ? row1 : row0;

    always_comb begin
      wr_en   = 1'b0;
      wr_row  = lane_row;
      wr_byte = st_rot[31 - 8*l -: 8];
      if (clr_q) begin
        wr_en   = 1'b1;
        wr_row  = clr_row_q;
        wr_byte = '0;
      end else if (req_i.st_en) begin
        wr_en = 1'b1;
      end else if (req_i.pl_en && (off == Lane)) begin
        wr_en   = 1'b1;
        wr_row  = row0;
        wr_byte = req_i.wdata[7:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem[wr_row] <= wr_byte;
      end
      if (req_i.rd_en) begin
        rd_q <= mem[lane_row];
      end
    end

    assign lanes_w[31 - 8*l -: 8] = rd_q;
  end

  // rotate lanes back so the byte at the base address lands in [31:24]
  assign rd_dbl  = {lanes_w, lanes_w} << {off_q, 3'b000};
  assign rdata_o = rd_dbl[63:32];

endmodule

FILE: src/mips_subset_instruction_step_top.sv
// Top level: MIPS subset instruction step with register file, PC and data memory.
//
//  channel | dir | handshake                 | payload
//  in      | in  | in_valid_i / in_ready_o   | in_item_i  (msis_pkg::in_item_t)
//  out     | out | out_valid_o / out_ready_i | out_item_o (msis_pkg::out_item_t)
//
// One item per cycle sustained while out_ready_i is high; out_valid_o rises when an item
// reaches the output stage (register file read, then execute / data memory access into it).
// Register writes retire as results leave; later items forward from the output
// stage and from the last written register, so back-to-back dependences never stall.
// After reset a clearing pass zeroes the data memory row by row, during which
// in_ready_o is low. A stalled output holds the execute stage,
// which then holds the input.
module mips_subset_instruction_step_top #(
  parameter int unsigned DATA_BYTES = msis_pkg::DataBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msis_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msis_pkg::out_item_t out_item_o
);

  // register file: two read ports, registered data
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] rf_a_q, rf_b_q;
  logic        va_q, vb_q;

  // last retired register write
  logic        w_valid_q;
  logic [4:0]  w_idx_q;
  logic [31:0] w_val_q;

  logic                s1_valid_q;
  msis_pkg::in_item_t  s1_item_q;
  logic                s2_valid_q;
  msis_pkg::out_item_t s2_q;
  logic                s2_lw_q;
  logic [31:0]         pc_q;

  logic                accept, adv, out_fire, rf_we;
  logic                dmem_busy;
  logic [31:0]         dmem_rdata;
  msis_pkg::dmem_req_t dmem_req;

  logic [31:0]         ins;
  msis_pkg::opcode_e   op;
  logic [4:0]          rs, rt, rd;
  logic [31:0]         simm, ra, rb, ea, ea_wrap, pc4, alu_res;
  msis_pkg::out_item_t res;
  logic                res_lw;

  assign accept     = in_valid_i && in_ready_o;
  assign adv        = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !dmem_busy && (!s1_valid_q || adv);
  assign out_fire   = out_valid_o && out_ready_i;
  assign rf_we      = out_fire && out_item_o.reg_written;

  assign out_valid_o = s2_valid_q;
  always_comb begin
    out_item_o = s2_q;
    if (s2_lw_q) begin
      out_item_o.reg_value = dmem_rdata;
    end
  end

  // ---------------- register file ----------------
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[out_item_o.reg_index] <= out_item_o.reg_value;
    end
    if (accept) begin
      rf_a_q <= rf_mem[in_item_i.instruction[25:21]];
      rf_b_q <= rf_mem[in_item_i.instruction[20:16]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q  <= '0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      w_valid_q <= 1'b0;
      w_idx_q   <= '0;
      w_val_q   <= '0;
    end else begin
      if (rf_we) begin
        rf_vld_q[out_item_o.reg_index] <= 1'b1;
        w_valid_q <= 1'b1;
        w_idx_q   <= out_item_o.reg_index;
        w_val_q   <= out_item_o.reg_value;
      end
      if (accept) begin
        va_q <= rf_vld_q[in_item_i.instruction[25:21]];
        vb_q <= rf_vld_q[in_item_i.instruction[20:16]];
      end
    end
  end

  // ---------------- execute ----------------
  assign ins  = s1_item_q.instruction;
  assign op   = msis_pkg::opcode_e'(ins[31:26]);
  assign rs   = ins[25:21];
  assign rt   = ins[20:16];
  assign rd   = ins[15:11];
  assign simm = {{16{ins[15]}}, ins[15:0]};

  // forwarding: pending result first, then the write that raced the read
  always_comb begin
    ra = va_q ? rf_a_q : '0;
    if (w_valid_q && (w_idx_q == rs)) begin
      ra = w_val_q;
    end
    if (s2_valid_q && out_item_o.reg_written && (out_item_o.reg_index == rs)) begin
      ra = out_item_o.reg_value;
    end
    rb = vb_q ? rf_b_q : '0;
    if (w_valid_q && (w_idx_q == rt)) begin
      rb = w_val_q;
    end
    if (s2_valid_q && out_item_o.reg_written && (out_item_o.reg_index == rt)) begin
      rb = out_item_o.reg_value;
    end
  end

  assign ea      = ra + simm;
  assign ea_wrap = ea & 32'(DATA_BYTES - 1);
  assign pc4     = pc_q + 32'd4;

  always_comb begin
    case (msis_pkg::alu_e'(ins[2:0]))
      msis_pkg::ALU_ADDU: alu_res = ra + rb;
      msis_pkg::ALU_SUBU: alu_res = ra - rb;
      msis_pkg::ALU_AND:  alu_res = ra & rb;
      msis_pkg::ALU_OR:   alu_res = ra | rb;
      msis_pkg::ALU_NOR:  alu_res = ~(ra | rb);
      default:            alu_res = '0;
    endcase
  end

  always_comb begin
    logic        wr;
    logic        lw;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    wr          = 1'b0;
    lw          = 1'b0;
    wr_idx      = rt;
    wr_val      = ea;
    res         = '0;
    res.next_pc = pc_q;
    res_lw      = 1'b0;
    if (s1_item_q.action) begin
      // preload: memory write only, PC holds
    end else if (ins == msis_pkg::HaltWord) begin
      res.halted = 1'b1;
    end else begin
      res.next_pc = pc4;
      case (op)
        msis_pkg::OP_RTYPE: begin
          wr     = 1'b1;
          wr_idx = rd;
          wr_val = alu_res;
        end
        msis_pkg::OP_LW: begin
          wr = 1'b1;
          lw = 1'b1;
        end
        msis_pkg::OP_SW: begin
          res.mem_written = 1'b1;
          res.mem_address = ea_wrap[15:0];
          res.mem_word    = rb;
        end
        msis_pkg::OP_ADDIU: begin
          wr = 1'b1;
        end
        msis_pkg::OP_BEQ: begin
          if (ra == rb) begin
            res.next_pc = pc4 + {simm[29:0], 2'b00};
          end
        end
        msis_pkg::OP_J: begin
          res.next_pc = {pc4[31:28], ins[25:0], 2'b00};
        end
        default: begin
        end
      endcase
      // register zero is never written
      if (wr && (wr_idx != '0)) begin
        res.reg_written = 1'b1;
        res.reg_index   = wr_idx;
        res.reg_value   = lw ? '0 : wr_val;
        res_lw          = lw;
      end
    end
  end

  always_comb begin
    dmem_req       = '0;
    dmem_req.rd_en = adv && res_lw;
    dmem_req.st_en = adv && res.mem_written;
    dmem_req.pl_en = adv && s1_item_q.action;
    if (s1_item_q.action) begin
      dmem_req.addr  = {16'b0, s1_item_q.load_address} & 32'(DATA_BYTES - 1);
      dmem_req.wdata = {24'b0, s1_item_q.load_byte};
    end else begin
      dmem_req.addr  = ea_wrap;
      dmem_req.wdata = rb;
    end
  end

  msis_dmem #(
    .DATA_BYTES(DATA_BYTES)
  ) u_dmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dmem_req),
    .rdata_o(dmem_rdata),
    .busy_o (dmem_busy)
  );

  // ---------------- pipeline control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_lw_q    <= 1'b0;
      pc_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        s2_valid_q <= 1'b1;
        s2_lw_q    <= res_lw;
        pc_q       <= res.next_pc;
      end else if (out_fire) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
    if (adv) begin
      s2_q <= res;
    end
  end

  // ---------------- assertions ----------------
  a_no_reg0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.reg_written && (out_item_o.reg_index == '0)))
    else $error("register zero reported as written");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dmem_busy |-> !in_ready_o)
    else $error("item accepted during memory clear");

  a_pc_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (pc_q == s2_q.next_pc))
    else $error("PC differs from next_pc of newest result");

  a_single_write_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.reg_written && out_item_o.mem_written))
    else $error("item wrote both register and memory");

  a_load_has_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_lw) |=> (s2_lw_q && out_item_o.reg_written))
    else $error("load result lost its register write");

endmodule
